// File: src/pold_pkg.sv
// Shared types, opcode constants and decode functions for the prefixed
// opcode length decoder. No dependencies; pold_decode, pold_out_reg and the top level use this package.
`timescale 1ns / 1ps
`default_nettype none

package pold_pkg;

    localparam logic [7:0] PREFIX_IX  = 8'hDD;
    localparam logic [7:0] PREFIX_IY  = 8'hFD;
    localparam logic [7:0] PREFIX_ED  = 8'hED;
    localparam logic [7:0] PREFIX_CB  = 8'hCB;
    localparam logic [7:0] MASK_YZ    = 8'hC7;
    localparam logic [7:0] MASK_PQ    = 8'hCF;
    localparam logic [7:0] MASK_JR    = 8'hE7;
    localparam logic [7:0] ALU_BASE   = 8'h80;
    localparam logic [7:0] OP_HALT    = 8'h76;
    localparam logic [3:0] LENGTH_MAX = 4'd15;

    typedef enum logic [2:0] {
        PH_START,
        PH_PAGEOP,
        PH_DISP,
        PH_IMM8,
        PH_WLO,
        PH_WHI,
        PH_REL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_WORD = 2'd2,
        KIND_REL  = 2'd3
    } imm_kind_t;

    typedef enum logic [1:0] {
        PAGE_MAIN = 2'd0,
        PAGE_CB   = 2'd1,
        PAGE_ED   = 2'd2
    } page_t;

    typedef enum logic [1:0] {
        INDEX_NONE = 2'd0,
        INDEX_IX   = 2'd1,
        INDEX_IY   = 2'd2
    } index_t;

    typedef struct packed {
        logic [15:0] start_address;
        logic [3:0]  length;
        index_t      index_select;
        page_t       page;
        logic [7:0]  opcode;
        logic        has_displacement;
        logic [7:0]  displacement;
        imm_kind_t   immediate_kind;
        logic [15:0] immediate;
        logic        undefined_ed;
    } result_t;

    // Operand kind that follows a main page opcode.
    function automatic imm_kind_t main_kind(input logic [7:0] op);
        if (op >= 8'h40 && op < 8'hC0) return KIND_NONE;
        if (op == 8'h01 || op == 8'h11 || op == 8'h21 || op == 8'h31) return KIND_WORD;
        if ((op & MASK_YZ) == 8'h06) return KIND_BYTE;
        if ((op & MASK_YZ) == 8'h04 || (op & MASK_YZ) == 8'h05 || (op & MASK_YZ) == 8'h03)
            return KIND_NONE;
        if ((op & MASK_PQ) == 8'h09) return KIND_NONE;
        if (op == 8'hD3 || op == 8'hDB) return KIND_BYTE;
        if (op == 8'hC3 || op == 8'hCD || op == 8'h22 || op == 8'h2A || op == 8'h32
            || op == 8'h3A)
            return KIND_WORD;
        if (op == 8'h10 || op == 8'h18 || (op & MASK_JR) == 8'h20) return KIND_REL;
        if ((op & MASK_YZ) == 8'hC2 || (op & MASK_YZ) == 8'hC4) return KIND_WORD;
        if ((op & MASK_YZ) == 8'hC6) return KIND_BYTE;
        return KIND_NONE;
    endfunction

    // An indexed main page opcode takes a displacement only where it names (HL).
    function automatic logic main_disp(input index_t idx, input logic [7:0] op);
        logic [2:0] a;
        logic [2:0] b;
        a = op[5:3];
        b = op[2:0];
        if (idx == INDEX_NONE) return 1'b0;
        if (op >= 8'h40 && op < ALU_BASE) return (op != OP_HALT) && (a == 3'd6 || b == 3'd6);
        if (op >= ALU_BASE && op < 8'hC0) return b == 3'd6;
        if ((op & MASK_YZ) == 8'h06 || (op & MASK_YZ) == 8'h04 || (op & MASK_YZ) == 8'h05)
            return a == 3'd6;
        return 1'b0;
    endfunction

    function automatic logic ed_word(input logic [7:0] op);
        return (op & MASK_PQ) == 8'h43 || (op & MASK_PQ) == 8'h4B;
    endfunction

    function automatic logic ed_undef(input logic [7:0] op);
        logic [7:0] lo;
        lo = op & MASK_YZ;
        if (lo == 8'h40 || lo == 8'h41 || lo == 8'h42 || lo == 8'h44 || lo == 8'h45
            || lo == 8'h46)
            return 1'b0;
        if (ed_word(op)) return 1'b0;
        case (op)
            8'h47, 8'h4F, 8'h57, 8'h5F, 8'h67, 8'h6F,
            8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA8, 8'hA9, 8'hAA, 8'hAB,
            8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB8, 8'hB9, 8'hBA, 8'hBB: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: src/pold_in_reg.sv
// Input register for code bytes and their addresses.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module pold_in_reg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic [15:0] in_addr,
    output logic             held_valid,
    input  wire logic        held_take,
    output logic [7:0]       held_byte,
    output logic [15:0]      held_addr
);

    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [15:0] addr_reg;

    // A new word may enter in the same cycle as the held one is consumed.
    assign in_ready   = !valid_reg || held_take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_addr  = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            addr_reg <= in_addr;
        end
    end

endmodule

`default_nettype wire

// File: src/pold_decode.sv
// Instruction splitting state machine: held instruction fields and the
// single-pass step for one code byte. Depends on pold_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pold_decode (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_take,
    input  wire logic [7:0]  code_byte,
    input  wire logic [15:0] byte_address,
    input  wire logic        result_room,
    output logic             result_load,
    output pold_pkg::result_t result
);

    pold_pkg::phase_t    phase_reg, phase_next, phase_step;
    logic [15:0]         start_reg, start_next, cur_start;
    pold_pkg::index_t    index_reg, index_next, cur_index;
    pold_pkg::page_t     page_reg, page_next, cur_page;
    logic [7:0]          op_reg, op_next, cur_op;
    logic [7:0]          disp_reg, disp_next, cur_disp;
    logic [7:0]          low_reg, low_next, cur_low;
    logic [3:0]          count_reg, count_next, cur_count;
    logic                emit;
    logic                clear;
    pold_pkg::imm_kind_t kind;
    logic                disp_taken;
    logic [15:0]         rel_target;

    // Step: the held fields as this byte updates them, and whether it ends
    // an instruction.
    always_comb
    begin
        cur_start  = (phase_reg == pold_pkg::PH_START && count_reg == 4'd0)
                     ? byte_address : start_reg;
        cur_count  = (count_reg == pold_pkg::LENGTH_MAX) ? count_reg : count_reg + 4'd1;
        cur_index  = index_reg;
        cur_page   = page_reg;
        cur_op     = op_reg;
        cur_disp   = disp_reg;
        cur_low    = low_reg;
        phase_step = phase_reg;
        emit       = 1'b0;
        clear      = 1'b0;
        kind       = pold_pkg::KIND_NONE;
        case (phase_reg)
            pold_pkg::PH_START:
            begin
                if (code_byte == pold_pkg::PREFIX_IX)
                begin
                    cur_index = pold_pkg::INDEX_IX;
                end
                else if (code_byte == pold_pkg::PREFIX_IY)
                begin
                    cur_index = pold_pkg::INDEX_IY;
                end
                else if (code_byte == pold_pkg::PREFIX_ED)
                begin
                    cur_page   = pold_pkg::PAGE_ED;
                    phase_step = pold_pkg::PH_PAGEOP;
                end
                else if (code_byte == pold_pkg::PREFIX_CB)
                begin
                    // Indexed CB puts the displacement before the opcode.
                    cur_page   = pold_pkg::PAGE_CB;
                    phase_step = (index_reg != pold_pkg::INDEX_NONE)
                                 ? pold_pkg::PH_DISP : pold_pkg::PH_PAGEOP;
                end
                else
                begin
                    cur_page = pold_pkg::PAGE_MAIN;
                    cur_op   = code_byte;
                    if (pold_pkg::main_disp(index_reg, code_byte))
                    begin
                        phase_step = pold_pkg::PH_DISP;
                    end
                    else
                    begin
                        case (pold_pkg::main_kind(code_byte))
                            pold_pkg::KIND_BYTE: phase_step = pold_pkg::PH_IMM8;
                            pold_pkg::KIND_WORD: phase_step = pold_pkg::PH_WLO;
                            pold_pkg::KIND_REL:  phase_step = pold_pkg::PH_REL;
                            default:             emit = 1'b1;
                        endcase
                    end
                end
            end
            pold_pkg::PH_PAGEOP:
            begin
                cur_op = code_byte;
                if (page_reg == pold_pkg::PAGE_ED && pold_pkg::ed_word(code_byte))
                begin
                    phase_step = pold_pkg::PH_WLO;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            pold_pkg::PH_DISP:
            begin
                cur_disp = code_byte;
                if (page_reg == pold_pkg::PAGE_CB)
                begin
                    phase_step = pold_pkg::PH_PAGEOP;
                end
                else if (pold_pkg::main_kind(op_reg) == pold_pkg::KIND_BYTE)
                begin
                    phase_step = pold_pkg::PH_IMM8;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            pold_pkg::PH_IMM8:
            begin
                emit = 1'b1;
                kind = pold_pkg::KIND_BYTE;
            end
            pold_pkg::PH_WLO:
            begin
                cur_low    = code_byte;
                phase_step = pold_pkg::PH_WHI;
            end
            pold_pkg::PH_WHI:
            begin
                emit = 1'b1;
                kind = pold_pkg::KIND_WORD;
            end
            pold_pkg::PH_REL:
            begin
                emit = 1'b1;
                kind = pold_pkg::KIND_REL;
            end
            default:
            begin
                clear = 1'b1;
            end
        endcase
    end

    // A byte that finishes an instruction waits until the result register has room.
    assign byte_take   = byte_valid && (!emit || result_room);
    assign result_load = byte_take && emit;

    assign rel_target = byte_address + 16'd1 + {{8{code_byte[7]}}, code_byte};

    // Result record built from the updated fields.
    always_comb
    begin
        case (cur_page)
            pold_pkg::PAGE_CB: disp_taken = (cur_index != pold_pkg::INDEX_NONE);
            pold_pkg::PAGE_ED: disp_taken = 1'b0;
            default:           disp_taken = pold_pkg::main_disp(cur_index, cur_op);
        endcase
        result.start_address    = cur_start;
        result.length           = cur_count;
        result.index_select     = cur_index;
        result.page             = cur_page;
        result.opcode           = cur_op;
        result.has_displacement = disp_taken;
        result.displacement     = disp_taken ? cur_disp : 8'd0;
        result.immediate_kind   = kind;
        case (kind)
            pold_pkg::KIND_BYTE: result.immediate = {8'd0, code_byte};
            pold_pkg::KIND_WORD: result.immediate = {code_byte, cur_low};
            pold_pkg::KIND_REL:  result.immediate = rel_target;
            default:             result.immediate = 16'd0;
        endcase
        result.undefined_ed = (cur_page == pold_pkg::PAGE_ED) && pold_pkg::ed_undef(cur_op);
    end

    // Next state: a finished instruction clears everything it held.
    always_comb
    begin
        if (emit || clear)
        begin
            phase_next = pold_pkg::PH_START;
            start_next = 16'd0;
            index_next = pold_pkg::INDEX_NONE;
            page_next  = pold_pkg::PAGE_MAIN;
            op_next    = 8'd0;
            disp_next  = 8'd0;
            low_next   = 8'd0;
            count_next = 4'd0;
        end
        else
        begin
            phase_next = phase_step;
            start_next = cur_start;
            index_next = cur_index;
            page_next  = cur_page;
            op_next    = cur_op;
            disp_next  = cur_disp;
            low_next   = cur_low;
            count_next = cur_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pold_pkg::PH_START;
            start_reg <= 16'd0;
            index_reg <= pold_pkg::INDEX_NONE;
            page_reg  <= pold_pkg::PAGE_MAIN;
            op_reg    <= 8'd0;
            disp_reg  <= 8'd0;
            low_reg   <= 8'd0;
            count_reg <= 4'd0;
        end
        else if (byte_take)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            index_reg <= index_next;
            page_reg  <= page_next;
            op_reg    <= op_next;
            disp_reg  <= disp_next;
            low_reg   <= low_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (count_reg == 4'd0 && phase_reg == pold_pkg::PH_START))
        else $error("held byte count not cleared after a result");
    a_undef_page: assert property (@(posedge clk) disable iff (!rst_n)
        result_load && result.undefined_ed |-> result.page == pold_pkg::PAGE_ED)
        else $error("undefined flag raised outside the ED page");
    a_disp_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_load && result.has_displacement |-> result.index_select != pold_pkg::INDEX_NONE)
        else $error("displacement reported without an index prefix");
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> result_room && result.length != 4'd0)
        else $error("result loaded without room or with zero length");
`endif

endmodule

`default_nettype wire

// File: src/pold_out_reg.sv
// Result register between the decoder and the output stream.
// Depends on pold_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module pold_out_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire pold_pkg::result_t result_in,
    output logic              room,
    output logic              out_valid,
    input  wire logic         out_ready,
    output pold_pkg::result_t result_out
);

    logic              valid_reg;
    pold_pkg::result_t result_reg;

    // The register may be refilled in the cycle its word leaves.
    assign room       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

// File: src/prefixed_opcode_length_decoder_core.sv
// Prefixed opcode length decoder, top level: stream ports and packing.
// Depends on pold_pkg, pold_in_reg, pold_decode and pold_out_reg.
//
// The block takes one code byte per clock with its address and splits the
// stream into instructions: index prefixes, CB/ED/main opcode, displacement
// and operand bytes. For each finished instruction it sends one result word;
// other bytes send nothing. A byte is held in the input register and is
// decoded in a single pass into the result register, from which its result
// word is offered. Sustained rate is one byte per cycle while the result
// register drains, as the decoder state updates once per byte. A full result
// register that is not drained stalls only bytes that finish an instruction.
`timescale 1ns / 1ps
`default_nettype none

module prefixed_opcode_length_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // code_byte [7:0], byte_address [23:8]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // start_address [15:0], length [19:16], opcode [27:20], displacement [35:28],
    // immediate [51:36], zero [55:52]
    output logic [55:0]      m_tdata,
    // index_select [1:0], page [3:2], has_displacement [4], immediate_kind [6:5],
    // undefined_ed [7]
    output logic [7:0]       m_tuser
);

    logic              held_valid;
    logic              held_take;
    logic [7:0]        held_byte;
    logic [15:0]       held_addr;
    logic              result_room;
    logic              result_load;
    pold_pkg::result_t result;
    pold_pkg::result_t out_result;

    pold_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata[7:0]),
        .in_addr    (s_tdata[23:8]),
        .held_valid (held_valid),
        .held_take  (held_take),
        .held_byte  (held_byte),
        .held_addr  (held_addr)
    );

    pold_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (held_valid),
        .byte_take    (held_take),
        .code_byte    (held_byte),
        .byte_address (held_addr),
        .result_room  (result_room),
        .result_load  (result_load),
        .result       (result)
    );

    pold_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (result_load),
        .result_in  (result),
        .room       (result_room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result_out (out_result)
    );

    assign m_tdata = {4'd0,
                      out_result.immediate,
                      out_result.displacement,
                      out_result.opcode,
                      out_result.length,
                      out_result.start_address};

    assign m_tuser = {out_result.undefined_ed,
                      out_result.immediate_kind,
                      out_result.has_displacement,
                      out_result.page,
                      out_result.index_select};

endmodule

`default_nettype wire
